>>> rtl/core/sepws_pkg.sv
package sepws_pkg;

  // Page size of the device, a power of two
  localparam int PageBytes = 64;
  localparam int PageBits  = $clog2(PageBytes);

  // Command queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  typedef logic [QPtrW-1:0] qptr_t;
  typedef logic [QPtrW:0]   qcnt_t;
  typedef logic [3:0]       step_t;

  // SPI command bytes
  localparam logic [7:0] SpiRead   = 8'h03;
  localparam logic [7:0] SpiWrite  = 8'h02;
  localparam logic [7:0] SpiWren   = 8'h06;
  localparam logic [7:0] SpiRdsr   = 8'h05;
  localparam logic [7:0] SpiDummy  = 8'h00;
  localparam logic [15:0] CountMax = 16'hFFFF;
  localparam logic [15:0] PollLimitReset = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_START_READ  = 3'd0,
    OP_START_WRITE = 3'd1,
    OP_WRITE_BYTE  = 3'd2,
    OP_READ_BYTE   = 3'd3,
    OP_REPLY       = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ACT_CS_LOW  = 3'd0,
    ACT_CS_HIGH = 3'd1,
    ACT_GAP     = 3'd2,
    ACT_SEND    = 3'd3,
    ACT_CAPTURE = 3'd4,
    ACT_HOST    = 3'd5,
    ACT_DONE    = 3'd6,
    ACT_FAILED  = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    M_IDLE        = 3'd0,
    M_POLL_READ   = 3'd1,
    M_POLL_WRITE  = 3'd2,
    M_POLL_PAGE   = 3'd3,
    M_READ_READY  = 3'd4,
    M_READ_WAIT   = 3'd5,
    M_WRITE_READY = 3'd6
  } mode_e;

  // Beat programs run by the back end
  typedef enum logic [2:0] {
    FAM_POLL    = 3'd0,
    FAM_WRITE   = 3'd1,
    FAM_READ    = 3'd2,
    FAM_FAIL    = 3'd3,
    FAM_CAPTURE = 3'd4,
    FAM_REPLY   = 3'd5
  } family_e;

  // Program step numbers
  localparam step_t PollCsHigh   = 4'd0;
  localparam step_t PollFirst    = 4'd1;
  localparam step_t PollLast     = 4'd4;
  localparam step_t WrOpenFirst  = 4'd0;
  localparam step_t WrOpenLast   = 4'd7;
  localparam step_t WrData       = 4'd8;
  localparam step_t WrDone       = 4'd10;
  localparam step_t RdOpenLast   = 4'd3;
  localparam step_t ReplyDone    = 4'd2;
  localparam step_t StepZero     = 4'd0;

  typedef struct packed {
    family_e     family;
    step_t       start_step;
    step_t       end_step;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] count;
  } cmd_t;

endpackage

>>> rtl/core/sepws_in_if.sv
interface sepws_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] address;
  logic [7:0]  data;
  logic        last;

  modport source (output valid, opcode, address, data, last, input ready);
  modport sink   (input valid, opcode, address, data, last, output ready);
endinterface

>>> rtl/core/sepws_out_if.sv
interface sepws_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  spi_byte;
  logic [7:0]  host_data;
  logic [15:0] byte_count;
  logic        final_res;

  modport source (output valid, action, spi_byte, host_data, byte_count, final_res,
                  input ready);
  modport sink   (input valid, action, spi_byte, host_data, byte_count, final_res,
                  output ready);
endinterface

>>> rtl/core/sepws_front.sv
module sepws_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_data_i,
  sepws_in_if.sink          in_i,
  input  logic              q_full_i,
  output logic              push_o,
  output sepws_pkg::cmd_t   cmd_o
);

  sepws_pkg::mode_e mode_q, mode_d;
  logic [15:0] poll_limit_q;
  logic [15:0] addr_q, addr_d;
  logic [15:0] xfer_cnt_q, xfer_cnt_d;
  logic [15:0] poll_cnt_q, poll_cnt_d;
  logic [7:0]  held_byte_q, held_byte_d;
  logic        held_last_q, held_last_d;

  logic        beat;
  logic        poll_fail;
  logic        page_cross;
  logic [15:0] cnt_inc;
  sepws_pkg::opcode_e op;

  assign in_i.ready = !q_full_i;
  assign beat       = in_i.valid && in_i.ready;
  assign op         = sepws_pkg::opcode_e'(in_i.opcode);
  assign poll_fail  = poll_cnt_q >= poll_limit_q;
  assign page_cross = (xfer_cnt_q != '0) && (addr_q[sepws_pkg::PageBits-1:0] == '0);
  assign cnt_inc    = (xfer_cnt_q == sepws_pkg::CountMax) ? xfer_cnt_q
                                                          : xfer_cnt_q + 16'd1;

  // Next mode
  always_comb begin
    mode_d = mode_q;
    if (beat) begin
      unique case (mode_q)
        sepws_pkg::M_IDLE: begin
          if (op == sepws_pkg::OP_START_READ) mode_d = sepws_pkg::M_POLL_READ;
          else if (op == sepws_pkg::OP_START_WRITE) mode_d = sepws_pkg::M_POLL_WRITE;
        end
        sepws_pkg::M_POLL_READ, sepws_pkg::M_POLL_WRITE, sepws_pkg::M_POLL_PAGE: begin
          if (op == sepws_pkg::OP_REPLY) begin
            if (poll_fail) mode_d = sepws_pkg::M_IDLE;
            else if (!in_i.data[0]) begin
              if (mode_q == sepws_pkg::M_POLL_READ) mode_d = sepws_pkg::M_READ_READY;
              else if (mode_q == sepws_pkg::M_POLL_WRITE) mode_d = sepws_pkg::M_WRITE_READY;
              else mode_d = held_last_q ? sepws_pkg::M_IDLE : sepws_pkg::M_WRITE_READY;
            end
          end
        end
        sepws_pkg::M_READ_READY: begin
          if (op == sepws_pkg::OP_READ_BYTE) mode_d = sepws_pkg::M_READ_WAIT;
        end
        sepws_pkg::M_READ_WAIT: begin
          if (op == sepws_pkg::OP_REPLY)
            mode_d = held_last_q ? sepws_pkg::M_IDLE : sepws_pkg::M_READ_READY;
        end
        sepws_pkg::M_WRITE_READY: begin
          if (op == sepws_pkg::OP_WRITE_BYTE) begin
            if (page_cross) mode_d = sepws_pkg::M_POLL_PAGE;
            else if (in_i.last) mode_d = sepws_pkg::M_IDLE;
          end
        end
        default: mode_d = sepws_pkg::M_IDLE;
      endcase
    end
  end

  // Commands and data state
  always_comb begin
    push_o      = 1'b0;
    cmd_o       = '{family: sepws_pkg::FAM_POLL, start_step: sepws_pkg::PollFirst,
                    end_step: sepws_pkg::PollLast, addr: addr_q, data: in_i.data,
                    count: cnt_inc};
    addr_d      = addr_q;
    xfer_cnt_d  = xfer_cnt_q;
    poll_cnt_d  = poll_cnt_q;
    held_byte_d = held_byte_q;
    held_last_d = held_last_q;
    if (beat) begin
      unique case (mode_q)
        sepws_pkg::M_IDLE: begin
          if (op == sepws_pkg::OP_START_READ || op == sepws_pkg::OP_START_WRITE) begin
            push_o     = 1'b1;
            addr_d     = in_i.address;
            xfer_cnt_d = '0;
            poll_cnt_d = '0;
          end
        end
        sepws_pkg::M_POLL_READ, sepws_pkg::M_POLL_WRITE, sepws_pkg::M_POLL_PAGE: begin
          if (op == sepws_pkg::OP_REPLY) begin
            push_o = 1'b1;
            if (poll_fail) begin
              cmd_o.family     = sepws_pkg::FAM_FAIL;
              cmd_o.start_step = sepws_pkg::StepZero;
              cmd_o.end_step   = sepws_pkg::StepZero;
            end else begin
              poll_cnt_d = poll_cnt_q + 16'd1;
              if (!in_i.data[0]) begin
                if (mode_q == sepws_pkg::M_POLL_READ) begin
                  cmd_o.family     = sepws_pkg::FAM_READ;
                  cmd_o.start_step = sepws_pkg::StepZero;
                  cmd_o.end_step   = sepws_pkg::RdOpenLast;
                end else if (mode_q == sepws_pkg::M_POLL_WRITE) begin
                  cmd_o.family     = sepws_pkg::FAM_WRITE;
                  cmd_o.start_step = sepws_pkg::WrOpenFirst;
                  cmd_o.end_step   = sepws_pkg::WrOpenLast;
                end else begin
                  // reopen the page, then the held byte
                  cmd_o.family     = sepws_pkg::FAM_WRITE;
                  cmd_o.start_step = sepws_pkg::WrOpenFirst;
                  cmd_o.end_step   = held_last_q ? sepws_pkg::WrDone : sepws_pkg::WrData;
                  cmd_o.data       = held_byte_q;
                  xfer_cnt_d       = cnt_inc;
                  addr_d           = addr_q + 16'd1;
                end
              end
            end
          end
        end
        sepws_pkg::M_READ_READY: begin
          if (op == sepws_pkg::OP_READ_BYTE) begin
            push_o           = 1'b1;
            held_last_d      = in_i.last;
            cmd_o.family     = sepws_pkg::FAM_CAPTURE;
            cmd_o.start_step = sepws_pkg::StepZero;
            cmd_o.end_step   = sepws_pkg::StepZero;
          end
        end
        sepws_pkg::M_READ_WAIT: begin
          if (op == sepws_pkg::OP_REPLY) begin
            push_o           = 1'b1;
            xfer_cnt_d       = cnt_inc;
            cmd_o.family     = sepws_pkg::FAM_REPLY;
            cmd_o.start_step = sepws_pkg::StepZero;
            cmd_o.end_step   = held_last_q ? sepws_pkg::ReplyDone : sepws_pkg::StepZero;
          end
        end
        sepws_pkg::M_WRITE_READY: begin
          if (op == sepws_pkg::OP_WRITE_BYTE) begin
            push_o = 1'b1;
            if (page_cross) begin
              held_byte_d      = in_i.data;
              held_last_d      = in_i.last;
              poll_cnt_d       = '0;
              cmd_o.start_step = sepws_pkg::PollCsHigh;
            end else begin
              cmd_o.family     = sepws_pkg::FAM_WRITE;
              cmd_o.start_step = sepws_pkg::WrData;
              cmd_o.end_step   = in_i.last ? sepws_pkg::WrDone : sepws_pkg::WrData;
              xfer_cnt_d       = cnt_inc;
              addr_d           = addr_q + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= sepws_pkg::M_IDLE;
      poll_limit_q <= sepws_pkg::PollLimitReset;
      addr_q       <= '0;
      xfer_cnt_q   <= '0;
      poll_cnt_q   <= '0;
      held_byte_q  <= '0;
      held_last_q  <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      addr_q      <= addr_d;
      xfer_cnt_q  <= xfer_cnt_d;
      poll_cnt_q  <= poll_cnt_d;
      held_byte_q <= held_byte_d;
      held_last_q <= held_last_d;
      if (cfg_we_i) poll_limit_q <= cfg_data_i;
    end
  end

endmodule

>>> rtl/core/sepws_queue.sv
module sepws_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sepws_pkg::cmd_t push_cmd_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output sepws_pkg::cmd_t head_o
);

  sepws_pkg::cmd_t  entry_q [sepws_pkg::QDepth];
  sepws_pkg::qptr_t wr_ptr_q, rd_ptr_q;
  sepws_pkg::qcnt_t count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == sepws_pkg::qcnt_t'(sepws_pkg::QDepth);
  assign valid_o = count_q != '0;
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + sepws_pkg::qptr_t'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + sepws_pkg::qptr_t'(1);
      if (do_push && !do_pop) count_q <= count_q + sepws_pkg::qcnt_t'(1);
      else if (do_pop && !do_push) count_q <= count_q - sepws_pkg::qcnt_t'(1);
    end
  end

endmodule

>>> rtl/core/sepws_back.sv
module sepws_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  sepws_pkg::cmd_t q_head_i,
  output logic            pop_o,
  sepws_out_if.source     out_o
);

  sepws_pkg::cmd_t  cmd_q;
  sepws_pkg::step_t step_q;
  logic             busy_q;
  logic             beat, last_step, load;
  sepws_pkg::action_e act;
  logic [7:0]       spi;
  logic [7:0]       host;
  logic [15:0]      cnt;

  assign beat      = out_o.valid && out_o.ready;
  assign last_step = step_q == cmd_q.end_step;
  assign load      = !busy_q || (beat && last_step);
  assign pop_o     = load && q_valid_i;

  // Beat decode
  always_comb begin
    act  = sepws_pkg::ACT_CS_HIGH;
    spi  = '0;
    host = '0;
    cnt  = '0;
    unique case (cmd_q.family)
      sepws_pkg::FAM_POLL: begin
        case (step_q)
          4'd1:    act = sepws_pkg::ACT_CS_LOW;
          4'd2:    begin act = sepws_pkg::ACT_SEND; spi = sepws_pkg::SpiRdsr; end
          4'd3:    begin act = sepws_pkg::ACT_CAPTURE; spi = sepws_pkg::SpiDummy; end
          default: act = sepws_pkg::ACT_CS_HIGH;
        endcase
      end
      sepws_pkg::FAM_WRITE: begin
        case (step_q)
          4'd0:    act = sepws_pkg::ACT_CS_LOW;
          4'd1:    begin act = sepws_pkg::ACT_SEND; spi = sepws_pkg::SpiWren; end
          4'd2:    act = sepws_pkg::ACT_CS_HIGH;
          4'd3:    act = sepws_pkg::ACT_GAP;
          4'd4:    act = sepws_pkg::ACT_CS_LOW;
          4'd5:    begin act = sepws_pkg::ACT_SEND; spi = sepws_pkg::SpiWrite; end
          4'd6:    begin act = sepws_pkg::ACT_SEND; spi = cmd_q.addr[15:8]; end
          4'd7:    begin act = sepws_pkg::ACT_SEND; spi = cmd_q.addr[7:0]; end
          4'd8:    begin act = sepws_pkg::ACT_SEND; spi = cmd_q.data; end
          4'd9:    act = sepws_pkg::ACT_CS_HIGH;
          default: begin act = sepws_pkg::ACT_DONE; cnt = cmd_q.count; end
        endcase
      end
      sepws_pkg::FAM_READ: begin
        case (step_q)
          4'd0:    act = sepws_pkg::ACT_CS_LOW;
          4'd1:    begin act = sepws_pkg::ACT_SEND; spi = sepws_pkg::SpiRead; end
          4'd2:    begin act = sepws_pkg::ACT_SEND; spi = cmd_q.addr[15:8]; end
          default: begin act = sepws_pkg::ACT_SEND; spi = cmd_q.addr[7:0]; end
        endcase
      end
      sepws_pkg::FAM_FAIL: act = sepws_pkg::ACT_FAILED;
      sepws_pkg::FAM_CAPTURE: begin
        act = sepws_pkg::ACT_CAPTURE;
        spi = sepws_pkg::SpiDummy;
      end
      sepws_pkg::FAM_REPLY: begin
        case (step_q)
          4'd0:    begin act = sepws_pkg::ACT_HOST; host = cmd_q.data; end
          4'd1:    act = sepws_pkg::ACT_CS_HIGH;
          default: begin act = sepws_pkg::ACT_DONE; cnt = cmd_q.count; end
        endcase
      end
      default: act = sepws_pkg::ACT_FAILED;
    endcase
  end

  assign out_o.valid      = busy_q;
  assign out_o.action     = act;
  assign out_o.spi_byte   = spi;
  assign out_o.host_data  = host;
  assign out_o.byte_count = cnt;
  assign out_o.final_res  = last_step;

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= q_head_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (load) begin
      busy_q <= q_valid_i;
      if (q_valid_i) step_q <= q_head_i.start_step;
    end else if (beat) begin
      step_q <= step_q + sepws_pkg::step_t'(1);
    end
  end

endmodule

>>> rtl/core/spi_eeprom_page_write_sequencer_top.sv
// SPI EEPROM page write sequencer.
// in_i carries host and SPI reply items (opcode, address, data, last); out_o
// carries the actions for the SPI engine and the host (action, spi_byte,
// host_data, byte_count, final_res), one action per beat. final_res marks the
// last action caused by one input item. cfg_we_i/cfg_data_i load poll_limit.
// The front end takes one item per cycle while the four-entry command queue
// has room, updates the transfer state and queues at most one command per item.
// The back end plays each command out as 1 to 11 action beats, one per cycle
// while out_o.ready is high. With the back end idle, an item's command is
// registered in the queue and then in the back end, which raises out_o.valid.
// Throughput: one input beat per cycle; one output beat per cycle, so the
// output side sets the sustained pace when items cause several actions.
// A stalled receiver holds the current action; the front keeps taking items
// until the queue is full, then drops in_i.ready.
// Reset: idle, queue empty, poll_limit = 0xFFFF, no action pending.
module spi_eeprom_page_write_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  sepws_in_if.sink    in_i,
  sepws_out_if.source out_o
);

  logic            q_push, q_pop, q_full, q_valid;
  sepws_pkg::cmd_t q_in, q_head;

  // Front: classifies items and owns the transfer state
  sepws_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (q_in)
  );

  // Queue decouples input stalls from output stalls
  sepws_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_in),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // Back: expands commands into action beats
  sepws_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .pop_o     (q_pop),
    .out_o     (out_o)
  );

  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // Done always reports at least one byte and ends its item
  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.action == sepws_pkg::ACT_DONE) |->
      (out_o.byte_count != 16'd0 && out_o.final_res))
    else $error("done with zero count or not final");

  // Failure is a single final beat with count zero
  a_fail_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.action == sepws_pkg::ACT_FAILED) |->
      (out_o.final_res && out_o.byte_count == 16'd0))
    else $error("failed beat malformed");

  // Back end only pops when a command is there and current one is finished
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && out_o.valid) |-> (out_o.ready && out_o.final_res && q_valid))
    else $error("command popped mid-sequence");

endmodule
